// ===== rtl/pios_pkg.sv =====
// Package with shared types, register codes and constants of the point-in-shape test.
`timescale 1ns / 1ps
`default_nettype none
package pios_pkg;

   localparam int COORD_BITS = 20;
   localparam int CORD_W = 34;
   localparam int ANG_W = 26;
   localparam int ATAN_DEPTH = 24;

   localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd8388608;
   localparam logic [32:0] GAIN_Q32 = 33'd7072781452;
   localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;
   localparam logic signed [51:0] BOX_HI = 52'sd2147483648;
   localparam logic signed [51:0] BOX_LO = -52'sd2147483648;
   localparam logic [41:0] ANGLE_LIMIT = 42'd68719476736;

   localparam logic [ANG_W-1:0] ATAN_TURN [ATAN_DEPTH] = '{
      26'd2097152, 26'd1238021, 26'd654136, 26'd332050, 26'd166669, 26'd83416,
      26'd41718, 26'd20860, 26'd10430, 26'd5215, 26'd2608, 26'd1304,
      26'd652, 26'd326, 26'd163, 26'd81, 26'd41, 26'd20,
      26'd10, 26'd5, 26'd3, 26'd1, 26'd1, 26'd0
   };

   typedef enum logic [1:0] {
      KIND_BOX    = 2'd0,
      KIND_CYL    = 2'd1,
      KIND_SPHERE = 2'd2,
      KIND_SPARE  = 2'd3
   } shape_kind_type;

   typedef enum logic [2:0] {
      CSR_SHAPE_KIND    = 3'd0,
      CSR_ORIGIN        = 3'd1,
      CSR_AXIS_ROW0     = 3'd2,
      CSR_AXIS_ROW1     = 3'd3,
      CSR_AXIS_ROW2     = 3'd4,
      CSR_INV_SCALE     = 3'd5,
      CSR_ANGLE_START   = 3'd6,
      CSR_INV_SPAN      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic [19:0]                  point_index;
   } req_type;

   typedef struct packed {
      logic [19:0] echo_index;
      logic        inside_res;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/pios_cordic.sv =====
// Pipelined vectoring CORDIC giving magnitude and angle in fractions of a turn.
`timescale 1ns / 1ps
`default_nettype none
module pios_cordic import pios_pkg::*; #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire logic signed [CORD_W-1:0] in_x,
   input  wire logic signed [CORD_W-1:0] in_y,
   input  wire logic [SIDE_W-1:0]        in_side,
   output logic                          out_valid,
   output logic signed [CORD_W-1:0]      out_mag,
   output logic signed [ANG_W-1:0]       out_angle,
   output logic [SIDE_W-1:0]             out_side
);

   logic [STAGES:0]              v_ff;
   logic signed [CORD_W-1:0]     x_ff [STAGES+1];
   logic signed [CORD_W-1:0]     y_ff [STAGES+1];
   logic signed [ANG_W-1:0]      z_ff [STAGES+1];
   logic [SIDE_W-1:0]            side_ff [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         if (in_x[CORD_W-1]) begin
            x_ff[0] <= -in_x;
            y_ff[0] <= -in_y;
            z_ff[0] <= HALF_TURN;
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [CORD_W-1:0] xs;
      logic signed [CORD_W-1:0] ys;
      logic signed [CORD_W-1:0] x_in;
      logic signed [CORD_W-1:0] y_in;
      logic signed [ANG_W-1:0]  z_in;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!y_ff[i][CORD_W-1]) begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + $signed(ATAN_TURN[i]);
         end else begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - $signed(ATAN_TURN[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_mag   = x_ff[STAGES];
   assign out_angle = z_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule
`default_nettype wire

// ===== rtl/point_in_oriented_shape_test.sv =====
// Top level of the point-in-shape test for boxes, cylinder sectors and sphere sectors.
//
//   Port group   Direction   Handshake           Payload
//   req_         in          req_valid/ready     req_type (point and index)
//   rsp_         out         rsp_valid/ready     rsp_type (index and inside flag)
//   csr_         in          csr_we              csr_index, csr_wdata
//
// One point is taken every cycle while the pipeline is not held. The two CORDIC pipelines
// are placed one after the other. Reset is synchronous and clears all valid bits and loads
// the register defaults. When a result is held and rsp_ready is low, the whole pipeline
// holds and req_ready drops; no transfer is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module point_in_oriented_shape_test import pios_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [59:0] csr_wdata
);

   localparam int SIDE1_W = 56;
   localparam int SIDE2_W = 81;

   logic [1:0]  shape_kind_ff;
   logic [59:0] origin_ff;
   logic [47:0] axis_ff [3];
   logic [59:0] inv_scale_ff;
   logic [31:0] angle_start_ff;
   logic [31:0] inv_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_kind_ff  <= KIND_BOX;
         origin_ff      <= '0;
         axis_ff[0]     <= 48'd16384;
         axis_ff[1]     <= 48'd1073741824;
         axis_ff[2]     <= 48'd70368744177664;
         inv_scale_ff   <= 60'd72057662757470208;
         angle_start_ff <= '0;
         inv_span_ff    <= 32'd268439552;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHAPE_KIND:  shape_kind_ff  <= csr_wdata[1:0];
            CSR_ORIGIN:      origin_ff      <= csr_wdata;
            CSR_AXIS_ROW0:   axis_ff[0]     <= csr_wdata[47:0];
            CSR_AXIS_ROW1:   axis_ff[1]     <= csr_wdata[47:0];
            CSR_AXIS_ROW2:   axis_ff[2]     <= csr_wdata[47:0];
            CSR_INV_SCALE:   inv_scale_ff   <= csr_wdata;
            CSR_ANGLE_START: angle_start_ff <= csr_wdata[31:0];
            CSR_INV_SPAN:    inv_span_ff    <= csr_wdata[31:0];
         endcase
      end
   end

   logic advance;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Offset from the origin.
   logic              v1_ff;
   logic [19:0]       idx1_ff;
   logic signed [20:0] d_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx1_ff <= req.point_index;
         d_ff[0] <= 21'(req.point_x) - 21'($signed(origin_ff[19:0]));
         d_ff[1] <= 21'(req.point_y) - 21'($signed(origin_ff[39:20]));
         d_ff[2] <= 21'(req.point_z) - 21'($signed(origin_ff[59:40]));
      end
   end

   // Axis products.
   logic               v2_ff;
   logic [19:0]        idx2_ff;
   logic signed [36:0] p_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx2_ff <= idx1_ff;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[k][j] <= d_ff[j] * $signed(axis_ff[k][16*j +: 16]);
            end
         end
      end
   end

   // Dot products floored to 2^-6.
   logic               v3_ff;
   logic [19:0]        idx3_ff;
   logic signed [30:0] q_ff [3];
   logic signed [38:0] acc [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = 39'(p_ff[k][0]) + 39'(p_ff[k][1]) + 39'(p_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx3_ff <= idx2_ff;
         for (int k = 0; k < 3; k++) begin
            q_ff[k] <= acc[k][38:8];
         end
      end
   end

   // Box products and zero flags.
   logic               v4_ff;
   logic [19:0]        idx4_ff;
   logic signed [30:0] q4_ff [3];
   logic signed [51:0] bp_ff [3];
   logic               z01_ff;
   logic               centre_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx4_ff   <= idx3_ff;
         z01_ff    <= (q_ff[0] == '0) && (q_ff[1] == '0);
         centre_ff <= (q_ff[0] == '0) && (q_ff[1] == '0) && (q_ff[2] == '0);
         for (int k = 0; k < 3; k++) begin
            q4_ff[k] <= q_ff[k];
            bp_ff[k] <= q_ff[k] * $signed({1'b0, inv_scale_ff[20*k +: 20]});
         end
      end
   end

   logic [2:0]          box_ok;
   logic [SIDE1_W-1:0]  side1_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         box_ok[k] = (bp_ff[k] >= BOX_LO) && (bp_ff[k] <= BOX_HI);
      end
   end

   assign side1_in = {idx4_ff, box_ok, q4_ff[2], z01_ff, centre_ff};

   logic                     c1_valid;
   logic signed [CORD_W-1:0] c1_mag;
   logic signed [ANG_W-1:0]  c1_angle;
   logic [SIDE1_W-1:0]       c1_side;

   pios_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE1_W)
   ) u_cordic_az (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v4_ff),
      .in_x      (CORD_W'(q4_ff[0])),
      .in_y      (CORD_W'(q4_ff[1])),
      .in_side   (side1_in),
      .out_valid (c1_valid),
      .out_mag   (c1_mag),
      .out_angle (c1_angle),
      .out_side  (c1_side)
   );

   // Gain removal and azimuth offset.
   logic               c1_z01;
   logic [32:0]        m1_eff;
   logic [23:0]        a_eff;
   logic               v6_ff;
   logic [19:0]        idx6_ff;
   logic [2:0]         box6_ok_ff;
   logic signed [30:0] q2_6_ff;
   logic               centre6_ff;
   logic [32:0]        m1_ff;
   logic [52:0]        rho_prod_ff;
   logic [23:0]        delta_ff;

   assign c1_z01 = c1_side[1];
   assign m1_eff = c1_z01 ? '0 : c1_mag[32:0];
   assign a_eff  = c1_z01 ? '0 : c1_angle[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx6_ff     <= c1_side[55:36];
         box6_ok_ff  <= c1_side[35:33];
         q2_6_ff     <= c1_side[32:2];
         centre6_ff  <= c1_side[0];
         m1_ff       <= m1_eff;
         rho_prod_ff <= m1_eff * INV_GAIN_Q20;
         delta_ff    <= a_eff - {angle_start_ff[15:0], 8'd0};
      end
   end

   logic [SIDE2_W-1:0]       side2_in;
   logic                     c2_valid;
   logic signed [CORD_W-1:0] c2_mag;
   logic signed [ANG_W-1:0]  c2_angle;
   logic [SIDE2_W-1:0]       c2_side;

   assign side2_in = {idx6_ff, box6_ok_ff, centre6_ff, delta_ff, m1_ff};

   pios_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (SIDE2_W)
   ) u_cordic_pol (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v6_ff),
      .in_x      (CORD_W'(q2_6_ff)),
      .in_y      ({1'b0, rho_prod_ff[52:20]}),
      .in_side   (side2_in),
      .out_valid (c2_valid),
      .out_mag   (c2_mag),
      .out_angle (c2_angle),
      .out_side  (c2_side)
   );

   // Range products.
   logic               v8_ff;
   logic [19:0]        idx8_ff;
   logic [2:0]         box8_ok_ff;
   logic               centre8_ff;
   logic [52:0]        rad_prod_ff;
   logic [39:0]        az_prod_ff;
   logic signed [26:0] e_ff;
   logic [32:0]        rad_m;

   assign rad_m = (shape_kind_ff == KIND_CYL) ? c2_side[32:0] : c2_mag[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (advance) begin
         v8_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx8_ff     <= c2_side[80:61];
         box8_ok_ff  <= c2_side[60:58];
         centre8_ff  <= c2_side[57];
         rad_prod_ff <= rad_m * inv_scale_ff[19:0];
         az_prod_ff  <= c2_side[56:33] * inv_span_ff[15:0];
         e_ff        <= 27'(c2_angle) - $signed({3'd0, angle_start_ff[31:16], 8'd0});
      end
   end

   // Bound checks.
   logic        v9_ff;
   logic [19:0] idx9_ff;
   logic [2:0]  box9_ok_ff;
   logic        centre9_ff;
   logic        rad_ok_ff;
   logic        az_ok_ff;
   logic        pol_ok_ff;
   logic [41:0] pol_prod;

   assign pol_prod = e_ff[25:0] * inv_span_ff[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (advance) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx9_ff    <= idx8_ff;
         box9_ok_ff <= box8_ok_ff;
         centre9_ff <= centre8_ff;
         rad_ok_ff  <= rad_prod_ff <= 53'(GAIN_Q32);
         az_ok_ff   <= 42'(az_prod_ff) <= ANGLE_LIMIT;
         pol_ok_ff  <= !e_ff[26] && (pol_prod <= ANGLE_LIMIT);
      end
   end

   logic inside_in;

   always_comb begin
      unique case (shape_kind_ff)
         KIND_CYL:    inside_in = rad_ok_ff && az_ok_ff && box9_ok_ff[2];
         KIND_SPHERE: inside_in = centre9_ff || (rad_ok_ff && az_ok_ff && pol_ok_ff);
         default:     inside_in = &box9_ok_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.echo_index <= idx9_ff;
         rsp_ff.inside_res <= inside_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ===== tb/sv/point_in_oriented_shape_test_tb.sv =====
// Point-in-shape self-checking testbench: directed points; random points partly under random stalls.
`timescale 1ns / 1ps
`default_nettype none
module point_in_oriented_shape_test_tb;
   import pios_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = 2 * STAGES + 10;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [59:0] csr_wdata = '0;

   point_in_oriented_shape_test #(.CORDIC_STAGES(STAGES)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the shape registers.
   logic [1:0]  kind_reg;
   logic [59:0] origin_reg;
   logic [47:0] axis_reg [3];
   logic [59:0] scale_reg;
   logic [31:0] start_reg;
   logic [31:0] span_reg;

   req_type pending_points [$];
   rsp_type expected_hits [$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint vector_angle(longint x0, longint y0, output longint mag);
      longint x, y, z, xs, ys;
      x = x0;
      y = y0;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = longint'(HALF_TURN);
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += longint'(ATAN_TURN[i]);
         end else begin
            x -= ys;
            y += xs;
            z -= longint'(ATAN_TURN[i]);
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic bit centred_in(longint q, longint inv);
      longint p;
      p = q * inv;
      return p >= -64'sd2147483648 && p <= 64'sd2147483648;
   endfunction

   function automatic bit radius_in(longint m, longint inv);
      longint unsigned p;
      p = longint'(m) * inv;
      return p <= 64'd7072781452;
   endfunction

   function automatic bit azimuth_in(longint a);
      longint unsigned st, delta;
      st = longint'(start_reg[15:0]) << 8;
      delta = (a - st) & 64'hFFFFFF;
      return delta * longint'(span_reg[15:0]) <= (64'd1 << 36);
   endfunction

   function automatic rsp_type predict_hit(req_type pt);
      longint d [3], q [3], sc [3], acc, m, m1, m2, a, p, rho, e;
      bit in_shape;
      rsp_type r;
      d[0] = longint'(pt.point_x) - longint'($signed(origin_reg[19:0]));
      d[1] = longint'(pt.point_y) - longint'($signed(origin_reg[39:20]));
      d[2] = longint'(pt.point_z) - longint'($signed(origin_reg[59:40]));
      for (int j = 0; j < 3; j++) sc[j] = longint'(scale_reg[20*j +: 20]);
      for (int k = 0; k < 3; k++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += d[j] * longint'($signed(axis_reg[k][16*j +: 16]));
         q[k] = floor_shr(acc, 8);
      end
      if (kind_reg == KIND_CYL) begin
         m = 0;
         a = 0;
         if (q[0] != 0 || q[1] != 0) a = vector_angle(q[0], q[1], m);
         in_shape = radius_in(m, sc[0]) && azimuth_in(a) && centred_in(q[2], sc[2]);
      end else if (kind_reg == KIND_SPHERE) begin
         if (q[0] == 0 && q[1] == 0 && q[2] == 0) begin
            in_shape = 1'b1;
         end else begin
            m1 = 0;
            a = 0;
            if (q[0] != 0 || q[1] != 0) a = vector_angle(q[0], q[1], m1);
            rho = longint'((longint'(m1) * 64'd636751) >> 20);
            p = vector_angle(q[2], rho, m2);
            e = p - (longint'(start_reg[31:16]) << 8);
            in_shape = radius_in(m2, sc[0]) && azimuth_in(a) && e >= 0 &&
                       longint'(e) * longint'(span_reg[31:16]) <= (64'd1 << 36);
         end
      end else begin
         in_shape = centred_in(q[0], sc[0]) && centred_in(q[1], sc[1]) &&
                    centred_in(q[2], sc[2]);
      end
      r.echo_index = pt.point_index;
      r.inside_res = in_shape;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Driver: feeds points from the pending queue.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_points.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               req <= pending_points[0];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Monitor: input transfers are predicted, and every result transfer is compared with
   // the oldest prediction.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_taken = 1'b1;
         expected_hits.push_back(predict_hit(req));
         void'(pending_points.pop_front());
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            report_mismatch("result without a pending point");
         end else begin
            if (rsp.echo_index !== expected_hits[0].echo_index)
               report_mismatch($sformatf("index got %0h want %0h", rsp.echo_index,
                                         expected_hits[0].echo_index));
            if (rsp.inside_res !== expected_hits[0].inside_res)
               report_mismatch($sformatf("inside got %0b want %0b for index %0h",
                                         rsp.inside_res, expected_hits[0].inside_res,
                                         expected_hits[0].echo_index));
            void'(expected_hits.pop_front());
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [59:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SHAPE_KIND: kind_reg = value[1:0];
         CSR_ORIGIN: origin_reg = value;
         CSR_AXIS_ROW0: axis_reg[0] = value[47:0];
         CSR_AXIS_ROW1: axis_reg[1] = value[47:0];
         CSR_AXIS_ROW2: axis_reg[2] = value[47:0];
         CSR_INV_SCALE: scale_reg = value;
         CSR_ANGLE_START: start_reg = value[31:0];
         default: span_reg = value[31:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_all();
      while (pending_points.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [19:0] rand_coord(int span);
      case ($urandom_range(9))
         0: return 20'h7FFFF;
         1: return 20'h80000;
         2: return 20'h0;
         default: return 20'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   task automatic queue_point(logic [19:0] x, logic [19:0] y, logic [19:0] z);
      req_type pt;
      pt.point_x = x;
      pt.point_y = y;
      pt.point_z = z;
      pt.point_index = 20'($urandom);
      pending_points.push_back(pt);
   endtask

   task automatic identity_setup(logic [1:0] kind);
      write_reg(CSR_SHAPE_KIND, 60'(kind));
      write_reg(CSR_ORIGIN, 60'd0);
      write_reg(CSR_AXIS_ROW0, 60'd16384);
      write_reg(CSR_AXIS_ROW1, 60'd1073741824);
      write_reg(CSR_AXIS_ROW2, 60'd70368744177664);
      write_reg(CSR_INV_SCALE, 60'd72057662757470208);
      write_reg(CSR_ANGLE_START, 60'd0);
      write_reg(CSR_INV_SPAN, 60'd268439552);
   endtask

   task automatic random_setup(int phase);
      logic [47:0] ax;
      logic [19:0] s [3];
      write_reg(CSR_SHAPE_KIND, 60'($urandom_range(3)));
      write_reg(CSR_ORIGIN, {20'($signed($urandom_range(8192)) - 4096),
                             20'($signed($urandom_range(8192)) - 4096),
                             20'($signed($urandom_range(8192)) - 4096)});
      for (int k = 0; k < 3; k++) begin
         if (phase % 4 == 3) ax = 48'({$urandom, $urandom});
         else ax = {16'($signed($urandom_range(32768)) - 16384),
                    16'($signed($urandom_range(32768)) - 16384),
                    16'($signed($urandom_range(32768)) - 16384)};
         write_reg(csr_index_type'(CSR_AXIS_ROW0 + k), 60'(ax));
      end
      for (int j = 0; j < 3; j++)
         s[j] = (phase % 4 == 2) ? 20'($urandom) : 20'($urandom_range(4096, 131072));
      write_reg(CSR_INV_SCALE, {s[2], s[1], s[0]});
      write_reg(CSR_ANGLE_START, 60'($urandom));
      write_reg(CSR_INV_SPAN, (phase % 4 == 1) ? 60'($urandom) :
                {28'd0, 16'($urandom_range(4096, 16384)), 16'($urandom_range(4096, 16384))});
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: each kind with identity axes, extremes, centre and axis points.
      for (int kind = 0; kind < 4; kind++) begin
         identity_setup(2'(kind));
         queue_point(20'h0, 20'h0, 20'h0);
         queue_point(20'h0, 20'h0, 20'd300);
         queue_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
         queue_point(20'h80000, 20'h80000, 20'h80000);
         queue_point(20'd512, 20'd512, 20'd512);
         queue_point(20'hFFE00, 20'd256, 20'hFFF00);
         drain_all();
      end
      // Extreme register settings.
      write_reg(CSR_SHAPE_KIND, 60'(KIND_SPHERE));
      write_reg(CSR_ORIGIN, '1);
      write_reg(CSR_INV_SCALE, '1);
      write_reg(CSR_ANGLE_START, 60'hFFFFFFFF);
      write_reg(CSR_INV_SPAN, 60'hFFFFFFFF);
      for (int i = 0; i < 4; i++) queue_point(rand_coord(524287), rand_coord(524287),
                                               rand_coord(524287));
      drain_all();

      for (int phase = 0; phase < 28; phase++) begin
         if (phase < 9) begin
            send_idle_pct = 16;
            recv_idle_pct = 74;
         end else if (phase < 18) begin
            send_idle_pct = 74;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_setup(phase);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(3) == 0)
               queue_point(rand_coord(524287), rand_coord(524287), rand_coord(524287));
            else
               queue_point(rand_coord(4096), rand_coord(4096), rand_coord(4096));
         end
         if (phase == 5) begin
            while (pending_points.size() > 25) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_hits.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_all();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== point_in_oriented_shape_test.f =====
rtl/pios_pkg.sv
rtl/pios_cordic.sv
rtl/point_in_oriented_shape_test.sv
tb/sv/point_in_oriented_shape_test_tb.sv
